// ----- rtl/core/frs_pkg.sv -----
`default_nettype none

package frs_pkg;

    // packet geometry
    localparam int MAX_FRAMES_PER_PACKET  = 100;
    localparam int BYTES_PER_STEREO_FRAME = 6;

    // nominal feed-forward, Q16 frames per packet
    localparam logic [22:0] NOMINAL_MAX   = 23'd8388607;
    localparam logic [22:0] NOMINAL_RESET = 23'd3145728;

    // below 1000 Hz the measured rate is ignored (1/16 Hz units)
    localparam logic [21:0] MEAS_FLOOR = 22'd16000;

    // floor(2^32 / 125), quotient may come out one low and is corrected
    localparam logic [25:0] RECIP_125 = 26'd34359738;
    localparam int          RECIP_SHIFT = 32;

    // ceil(2^21 / 125), exact for dividends below 21399
    localparam logic [14:0] SIL_RECIP = 15'd16778;
    localparam int          SIL_SHIFT = 21;

    // configuration reset values
    localparam logic [16:0] SAMPLE_RATE_RESET = 17'd48000;
    localparam logic [10:0] TARGET_FILL_RESET = 11'd256;
    localparam logic [15:0] GAIN_RESET        = 16'd524;
    localparam logic [20:0] MAX_CORR_RESET    = 21'd131072;

    typedef enum logic [1:0] {
        CFG_SAMPLE_RATE = 2'd0,
        CFG_TARGET_FILL = 2'd1,
        CFG_GAIN        = 2'd2,
        CFG_MAX_CORR    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_AUDIO     = 2'd0,
        KIND_NO_SIGNAL = 2'd1,
        KIND_PRIMING   = 2'd2,
        KIND_UNDERRUN  = 2'd3
    } packet_kind_t;

    typedef struct packed {
        logic        rx_stable;
        logic [2:0]  rate_code;
        logic [21:0] measured_rate_x16;
        logic [11:0] fifo_words;
    } frs_in_t;

    typedef struct packed {
        logic [6:0]   frame_count;
        logic [9:0]   byte_count;
        packet_kind_t packet_kind;
    } frs_out_t;

    // per-item control that rides along the pipeline
    typedef struct packed {
        logic        rx_stable;
        logic [2:0]  rate_code;
        logic [10:0] avail;
    } frs_ctx_t;

endpackage

`default_nettype wire

// ----- rtl/core/frs_div125.sv -----
`default_nettype none

module frs_div125 (
    input  logic        clk,
    input  logic        en,
    input  logic [30:0] dividend,
    output logic [22:0] quotient
);
    import frs_pkg::*;

    logic [56:0] prod;
    logic [24:0] q0_next;
    logic [24:0] q0_reg;
    logic [30:0] x_next;
    logic [30:0] x_reg;
    logic [30:0] rem;
    logic [24:0] q_fix;
    logic [22:0] quot_next;
    logic [22:0] quot_reg;

    // reciprocal estimate, at most one low
    always_comb
    begin
        prod    = dividend * RECIP_125;
        q0_next = prod[56:RECIP_SHIFT];
        x_next  = dividend;
    end

    // one correction step, then saturate to the nominal range
    always_comb
    begin
        rem   = x_reg - (31'(q0_reg) * 31'd125);
        q_fix = (rem >= 31'd125) ? q0_reg + 25'd1 : q0_reg;
        quot_next = (q_fix > 25'(NOMINAL_MAX)) ? NOMINAL_MAX : q_fix[22:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_reg   <= q0_next;
            x_reg    <= x_next;
            quot_reg <= quot_next;
        end
    end

    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ----- rtl/core/frs_corr.sv -----
`default_nettype none

module frs_corr (
    input  logic               clk,
    input  logic               en,
    input  logic [10:0]        avail,
    input  logic [10:0]        target,
    input  logic [15:0]        gain,
    input  logic [20:0]        max_corr,
    output logic signed [21:0] corr
);
    import frs_pkg::*;

    logic signed [11:0] err;
    logic signed [28:0] prod_next;
    logic signed [28:0] prod_reg;
    logic signed [28:0] lim;
    logic signed [21:0] corr_next;
    logic signed [21:0] corr_reg;

    // fill error times gain, Q16
    always_comb
    begin
        err       = $signed({1'b0, avail}) - $signed({1'b0, target});
        prod_next = $signed({1'b0, gain}) * err;
    end

    // clamp to +-max_corr
    always_comb
    begin
        lim = $signed({8'd0, max_corr});
        if (prod_reg > lim)
        begin
            corr_next = lim[21:0];
        end
        else if (prod_reg < -lim)
        begin
            corr_next = 22'(-lim);
        end
        else
        begin
            corr_next = prod_reg[21:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            corr_reg <= corr_next;
        end
    end

    assign corr = corr_reg;

endmodule

`default_nettype wire

// ----- rtl/core/frs_servo.sv -----
`default_nettype none

module frs_servo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid_in,
    input  frs_pkg::frs_ctx_t  ctx,
    input  logic [22:0]        nominal_new,
    input  logic signed [21:0] corr,
    input  logic [10:0]        target,
    input  logic [16:0]        sample_rate,
    output logic               out_valid,
    output frs_pkg::frs_out_t  out_data
);
    import frs_pkg::*;

    logic        primed_reg, primed_next;
    logic [15:0] frac_reg, frac_next;
    logic [22:0] nominal_reg, nominal_next;
    logic [2:0]  last_code_reg, last_code_next;
    logic        out_valid_reg, out_valid_next;
    frs_out_t    out_data_reg, out_data_next;
    logic [6:0]  silence_reg, silence_next;

    logic [28:0]        sil_prod;
    logic [7:0]         sil_raw;
    logic               rate_change;
    logic [22:0]        nominal_eff;
    logic               prime_now;
    logic [15:0]        frac_use;
    logic signed [24:0] sum;
    logic [23:0]        sum_pos;
    logic [7:0]         n_raw;
    logic [7:0]         n_cap;
    logic [6:0]         n_fin;
    logic [6:0]         frames;
    packet_kind_t       kind;
    logic               upd;

    // silence length: sample_rate / 1000 as (sample_rate / 8) / 125
    always_comb
    begin
        sil_prod     = sample_rate[16:3] * SIL_RECIP;
        sil_raw      = sil_prod[28:SIL_SHIFT];
        silence_next = (sil_raw > 8'(MAX_FRAMES_PER_PACKET)) ?
                       7'(MAX_FRAMES_PER_PACKET) : sil_raw[6:0];
    end

    assign upd = en && valid_in;

    always_comb
    begin
        rate_change = (ctx.rate_code != last_code_reg) && (ctx.rate_code != 3'd0);
        nominal_eff = rate_change ? nominal_new : nominal_reg;
        prime_now   = !primed_reg && (ctx.avail >= target);
        frac_use    = (rate_change || prime_now) ? 16'd0 : frac_reg;

        sum     = $signed({9'd0, frac_use}) + $signed({2'd0, nominal_eff})
                + 25'(corr);
        sum_pos = sum[24] ? 24'd0 : sum[23:0];
        n_raw   = sum_pos[23:16];
        n_cap   = (n_raw > 8'(MAX_FRAMES_PER_PACKET)) ?
                  8'(MAX_FRAMES_PER_PACKET) : n_raw;
        n_fin   = (11'(n_cap) > ctx.avail) ? ctx.avail[6:0] : n_cap[6:0];
    end

    // state and packet choice
    always_comb
    begin
        primed_next    = primed_reg;
        frac_next      = frac_reg;
        nominal_next   = nominal_reg;
        last_code_next = last_code_reg;
        frames         = silence_reg;
        kind           = KIND_NO_SIGNAL;
        if (!ctx.rx_stable)
        begin
            primed_next = 1'b0;
            frac_next   = 16'd0;
        end
        else
        begin
            if (rate_change)
            begin
                last_code_next = ctx.rate_code;
                nominal_next   = nominal_new;
                frac_next      = 16'd0;
            end
            if (!primed_reg && !prime_now)
            begin
                kind = KIND_PRIMING;
            end
            else if (n_fin == 7'd0)
            begin
                primed_next = 1'b0;
                frac_next   = sum_pos[15:0];
                kind        = KIND_UNDERRUN;
            end
            else
            begin
                primed_next = 1'b1;
                frac_next   = sum_pos[15:0];
                frames      = n_fin;
                kind        = KIND_AUDIO;
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = en ? valid_in : out_valid_reg;
        out_data_next  = out_data_reg;
        if (upd)
        begin
            out_data_next.frame_count = frames;
            out_data_next.byte_count  = 10'(frames) * 10'(BYTES_PER_STEREO_FRAME);
            out_data_next.packet_kind = kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg    <= 1'b0;
            frac_reg      <= 16'd0;
            nominal_reg   <= NOMINAL_RESET;
            last_code_reg <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (upd)
            begin
                primed_reg    <= primed_next;
                frac_reg      <= frac_next;
                nominal_reg   <= nominal_next;
                last_code_reg <= last_code_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        silence_reg  <= silence_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_audio_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.packet_kind == KIND_AUDIO)
        |-> (out_data_reg.frame_count != 7'd0))
        else $error("audio packet with zero frames");

    a_frames_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.frame_count <= 7'(MAX_FRAMES_PER_PACKET)))
        else $error("frame count above packet maximum");

    a_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.byte_count ==
            10'(out_data_reg.frame_count) * 10'(BYTES_PER_STEREO_FRAME)))
        else $error("byte count does not match frame count");

    a_lock_loss: assert property (@(posedge clk) disable iff (!rst_n)
        upd && !ctx.rx_stable |=> !primed_reg && (frac_reg == 16'd0)
            && (out_data_reg.packet_kind == KIND_NO_SIGNAL))
        else $error("lock loss did not reset the servo");

    a_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        upd && (kind == KIND_UNDERRUN) |=> !primed_reg)
        else $error("underrun left servo primed");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/fifo_fill_rate_servo.sv -----
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+--------------------------------------
// in       | input     | in_valid / in_ready  | in_data: lock, rate code, rate, fill
// out      | output    | out_valid / out_ready| out_data: frames, bytes, packet kind
// cfg      | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// one transaction per clock sustained while out_ready does not hold the pipeline; an
// item taken passes the input register at the accepting edge, two stages of the
// divide-by-125 reciprocal unit and of the gain multiply and clamp, then the servo
// update into the output register, where out_valid rises for it
// rst_n is asynchronous, active low; no clearing pass, the block is ready at once
// the whole pipeline holds while out_valid is high and out_ready is low,
// so in_ready follows out_ready one for one in that case
`default_nettype none

module fifo_fill_rate_servo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  frs_pkg::frs_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output frs_pkg::frs_out_t out_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [20:0]       cfg_data
);
    import frs_pkg::*;

    // configuration registers
    logic [16:0] sample_rate_reg;
    logic [10:0] target_fill_reg;
    logic [15:0] gain_reg;
    logic [20:0] max_corr_reg;

    // pipeline valids
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;

    // input register and per-item control
    frs_in_t  in_data_reg;
    frs_ctx_t ctx_s1, ctx_s2_reg, ctx_s3_reg;

    logic        adv;
    logic [30:0] dividend;
    logic [22:0] nominal_new;
    logic signed [21:0] corr;

    // every stage moves together unless a finished result is waiting
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= SAMPLE_RATE_RESET;
            target_fill_reg <= TARGET_FILL_RESET;
            gain_reg        <= GAIN_RESET;
            max_corr_reg    <= MAX_CORR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SAMPLE_RATE: sample_rate_reg <= cfg_data[16:0];
                CFG_TARGET_FILL: target_fill_reg <= cfg_data[10:0];
                CFG_GAIN:        gain_reg        <= cfg_data[15:0];
                CFG_MAX_CORR:    max_corr_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // payload stages carry no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_data_reg <= in_data;
            ctx_s2_reg  <= ctx_s1;
            ctx_s3_reg  <= ctx_s2_reg;
        end
    end

    // fifo_words is at most 4095, so the fifo size bound never bites;
    // frames waiting are half the subframe words
    always_comb
    begin
        ctx_s1.rx_stable = in_data_reg.rx_stable;
        ctx_s1.rate_code = in_data_reg.rate_code;
        ctx_s1.avail     = in_data_reg.fifo_words[11:1];
    end

    // nominal Q16 = rate * 65536 / 1000; both sources reduce to x / 125:
    // measured (1/16 Hz) as meas * 512 / 125, host (Hz) as host * 8192 / 125
    always_comb
    begin
        if (in_data_reg.measured_rate_x16 < MEAS_FLOOR)
        begin
            dividend = {1'b0, sample_rate_reg, 13'd0};
        end
        else
        begin
            dividend = {in_data_reg.measured_rate_x16, 9'd0};
        end
    end

    frs_div125 u_div (
        .clk      (clk),
        .en       (adv),
        .dividend (dividend),
        .quotient (nominal_new)
    );

    // proportional fill correction, clamped
    frs_corr u_corr (
        .clk      (clk),
        .en       (adv),
        .avail    (ctx_s1.avail),
        .target   (target_fill_reg),
        .gain     (gain_reg),
        .max_corr (max_corr_reg),
        .corr     (corr)
    );

    // accumulator, priming, underrun and the output register
    frs_servo u_servo (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .valid_in    (s3_valid_reg),
        .ctx         (ctx_s3_reg),
        .nominal_new (nominal_new),
        .corr        (corr),
        .target      (target_fill_reg),
        .sample_rate (sample_rate_reg),
        .out_valid   (out_valid),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire
